FILE: design/sorted_integer_list_macros.svh
// Assertion macros used by the sorted integer list checker.
`ifndef SORTED_INTEGER_LIST_MACROS_SVH
`define SORTED_INTEGER_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sil_pkg.sv
// Types and constants of the sorted integer list.
package sil_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int OP_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LIST   = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_op             op;
        logic [VALUE_W-1:0]   value;   // key for insert/delete compare
        logic [VALUE_W-1:0]   head;    // entry of cell 0, wraps to the tail on rotate
    } t_cell_cmd;

endpackage

FILE: design/sil_cell.sv
// One storage cell of the sorted chain: compare against the key and shift.
module sil_cell
    import sil_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_cmd          i_cmd,
    input  logic               i_valid,       // cell index below the count
    input  logic               i_tail,        // cell holds the last entry
    input  logic               i_left_lt,     // left neighbor is below the key
    input  logic [VALUE_W-1:0] i_left_value,
    input  logic [VALUE_W-1:0] i_right_value,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_lt,
    output logic               o_match
);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;
    logic               w_below;
    logic               w_ge;

    assign w_below = $signed(r_value) < $signed(i_cmd.value);
    assign o_lt    = i_valid && w_below;
    assign w_ge    = i_valid && !w_below;
    assign o_match = i_valid && (r_value == i_cmd.value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        case (i_cmd.op)
            CELL_INSERT: begin
                // first cell not below the key takes it, the rest shift right
                if (!o_lt) begin
                    n_value = i_left_lt ? i_cmd.value : i_left_value;
                end
            end
            CELL_DELETE: begin
                // first match sits at the first cell not below the key
                if (w_ge) begin
                    n_value = i_right_value;
                end
            end
            CELL_ROTATE: begin
                n_value = i_tail ? i_cmd.head : i_right_value;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: design/sorted_integer_list.sv
// Top level of the sorted integer list: cell chain, sequencer and output register.
//
// Holds up to CAPACITY signed 32-bit integers in ascending order in a chain of
// compare cells. Each input transfer carries an operation in s_axis_tuser
// (0 insert, 1 delete, 2 list, 3 no-op) and a value in s_axis_tdata. Insert
// and delete work on all cells at once: each cell compares its entry with the
// value and shifts one place right (insert) or left (delete). An insert into a
// full list is refused with status FULL; a delete of a value that is not held
// gives status NOT_FOUND. A list request gives one result per held entry, in
// ascending order, with tlast on the final one; the chain rotates one place
// per result, so a list takes max(count, 1) output transfers and holds off the
// input side until the last one is registered, after which the chain is back
// in order. An empty list gives one result with value zero and status EMPTY.
// Every result carries the count held after the operation in occupancy
// (masked to 5 bits). A single output register parts the two sides: a new
// item is taken while a finished result is being accepted downstream.
// Entry contents need no reset; the count resets to zero.
module sorted_integer_list
    import sil_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [31:0] value
    input  logic [1:0]  s_axis_tuser,    // [1:0] operation
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,    // [31:0] entry_value, [36:32] occupancy, rest zero
    output logic [1:0]  m_axis_tuser,    // [1:0] status
    output logic        m_axis_tlast     // last result of this item
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // ---------------------------------------------------------------- state
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_remain, n_remain;   // list results still to send

    logic                 r_m_valid, n_m_valid;
    logic [VALUE_W-1:0]   r_m_value, n_m_value;
    t_status              r_m_status, n_m_status;
    logic [OCC_W-1:0]     r_m_occ, n_m_occ;
    logic                 r_m_last, n_m_last;

    // ---------------------------------------------------------- chain wires
    logic [VALUE_W-1:0]   w_value [CAPACITY];
    logic [CAPACITY-1:0]  w_lt;
    logic [CAPACITY-1:0]  w_match;
    t_cell_cmd            w_cmd;

    logic                 w_out_free;
    logic                 w_accept;
    logic                 w_found;
    logic                 w_full;
    t_op                  w_op;

    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_found       = |w_match;
    assign w_full        = (r_count >= CNT_W'(CAPACITY));
    assign w_op          = t_op'(s_axis_tuser);

    // ---------------------------------------------------------- cell chain
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic               w_left_lt;
        logic [VALUE_W-1:0] w_left_value;
        logic [VALUE_W-1:0] w_right_value;

        if (gi == 0) begin : g_first
            // nothing sits left of cell 0: it takes the key when not below it
            assign w_left_lt    = 1'b1;
            assign w_left_value = w_value[0];
        end else begin : g_mid
            assign w_left_lt    = w_lt[gi-1];
            assign w_left_value = w_value[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign w_right_value = w_value[gi];
        end else begin : g_inner
            assign w_right_value = w_value[gi+1];
        end

        sil_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_valid       (CNT_W'(gi) < r_count),
            .i_tail        ((CNT_W'(gi) + CNT_W'(1)) == r_count),
            .i_left_lt     (w_left_lt),
            .i_left_value  (w_left_value),
            .i_right_value (w_right_value),
            .o_value       (w_value[gi]),
            .o_lt          (w_lt[gi]),
            .o_match       (w_match[gi])
        );
    end

    // ------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (w_op == OP_LIST) && (r_count > CNT_W'(1))) begin
                    n_state = S_LIST;
                end
            end
            S_LIST: begin
                if (w_out_free && (r_remain == CNT_W'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------- outputs
    always_comb begin
        w_cmd.op    = CELL_HOLD;
        w_cmd.value = s_axis_tdata;
        w_cmd.head  = w_value[0];

        n_count    = r_count;
        n_remain   = r_remain;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_value  = r_m_value;
        n_m_status = r_m_status;
        n_m_last   = r_m_last;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_m_valid  = 1'b1;
                    n_m_value  = s_axis_tdata;
                    n_m_status = ST_OK;
                    n_m_last   = 1'b1;
                    case (w_op)
                        OP_INSERT: begin
                            if (w_full) begin
                                n_m_status = ST_FULL;
                            end else begin
                                w_cmd.op = CELL_INSERT;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (w_found) begin
                                w_cmd.op = CELL_DELETE;
                                n_count  = r_count - CNT_W'(1);
                            end else begin
                                n_m_status = ST_NOT_FOUND;
                            end
                        end
                        OP_LIST: begin
                            if (r_count == '0) begin
                                n_m_value  = '0;
                                n_m_status = ST_EMPTY;
                            end else begin
                                // first entry goes out now, the chain rotates
                                w_cmd.op  = CELL_ROTATE;
                                n_m_value = w_value[0];
                                n_m_last  = (r_count == CNT_W'(1));
                                n_remain  = r_count - CNT_W'(1);
                            end
                        end
                        default: begin
                            // undefined operation: echo, list untouched
                            n_m_status = ST_OK;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (w_out_free) begin
                    w_cmd.op   = CELL_ROTATE;
                    n_m_valid  = 1'b1;
                    n_m_value  = w_value[0];
                    n_m_status = ST_OK;
                    n_m_last   = (r_remain == CNT_W'(1));
                    n_remain   = r_remain - CNT_W'(1);
                end
            end
            default: begin
                w_cmd.op = CELL_HOLD;
            end
        endcase

        n_m_occ = OCC_W'(n_count);
        if (!(w_accept || ((r_state == S_LIST) && w_out_free))) begin
            n_m_occ = r_m_occ;
        end
    end

    // ---------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_remain  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_remain  <= n_remain;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_value  <= n_m_value;
        r_m_status <= n_m_status;
        r_m_occ    <= n_m_occ;
        r_m_last   <= n_m_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_m_occ, r_m_value};
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tlast  = r_m_last;

endmodule

FILE: design/sil_checker.sv
// Port-level checker of the sorted integer list, bound to the top level.
`include "sorted_integer_list_macros.svh"

module sil_checker
    import sil_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic [1:0]  i_s_tuser,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] i_m_tdata,
    input logic [1:0]  i_m_tuser,
    input logic        i_m_tlast
);

    localparam int OCC_MAX = (CAPACITY < 31) ? CAPACITY : 31;

    // a stalled result stays offered
    `SIL_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid, "result dropped while stalled")

    // only ok results can be part of a multi-result list
    `SIL_ASSERT_SAME(a_err_last, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser != ST_OK), i_m_tlast, "error status without tlast")

    // an empty list reports zero value and zero occupancy
    `SIL_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser == ST_EMPTY), (i_m_tdata[36:0] == 37'd0), "empty status with data")

    // occupancy never exceeds the capacity
    `SIL_ASSERT_SAME(a_occ_max, i_clk, i_rst_n, i_m_tvalid, (i_m_tdata[36:32] <= OCC_MAX[4:0]), "occupancy above capacity")

    // no input is taken in the middle of a list stream
    `SIL_ASSERT_SAME(a_list_busy, i_clk, i_rst_n, i_m_tvalid && !i_m_tlast, !(i_s_tvalid && i_s_tready) || !i_m_tready || (i_s_tuser != i_s_tuser), "input taken during list")

endmodule

bind sorted_integer_list sil_checker #(
    .CAPACITY (CAPACITY)
) u_sil_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tuser  (s_axis_tuser),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_m_tlast  (m_axis_tlast)
);
